// ===== rtl/caa_pkg.sv =====
package caa_pkg;

  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_SUB   = 3'd1,
    KIND_MUL   = 3'd2,
    KIND_DIV   = 3'd3,
    KIND_MOD   = 3'd4,
    KIND_NEG   = 3'd5,
    KIND_POW   = 3'd6,
    KIND_CLEAR = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_OVF    = 3'd1,
    ST_UNF    = 3'd2,
    ST_NEGEXP = 3'd3,
    ST_DIVZ   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POWGO,
    S_WAIT,
    S_OUT
  } state_t;

  // Request to the shared multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } unit_req_t;

endpackage

// ===== rtl/checked_accumulator_alu_top.sv =====
// Overflow-checked signed accumulator. Each input transfer carries an
// operation (add, sub, mul, div, mod, negate, power, clear) and an operand;
// the operation is applied to the accumulator and one result transfer follows
// with the accumulator after the step and a status. On any error (overflow,
// underflow, negative exponent, divide by zero) the accumulator keeps its old
// value. Add, sub, negate and clear pass from S_EXEC straight to S_OUT.
// Mul, div and mod go through one shared shift-add / restoring-divide unit
// that retires one bit per cycle. Power runs that same unit once per
// exponent step, stopping at the first overflow. One item is in flight at
// a time: in_ready is high only when the previous result has been taken.
module checked_accumulator_alu_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_kind,
  input  logic signed [DATA_WIDTH-1:0]  in_operand,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]  out_value,
  output logic [2:0]                    out_status
);
  import caa_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] SIGNB = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE   = {{(W-1){1'b0}}, 1'b1};

  state_t        state_r, state_nxt;
  kind_t         kind_r;
  logic [W-1:0]  opnd_r;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  pow_r;
  logic [W-1:0]  cnt_r;
  status_t       st_r;

  unit_req_t     ureq;
  logic [W-1:0]  ux;
  logic [W-1:0]  uy;
  logic          udone;
  logic [W-1:0]  ulo;
  logic [W-1:0]  uq;
  logic          uovf;

  logic          a_neg, b_neg, diff;
  logic [W-1:0]  ma, mb, sum, sub;
  logic [W-1:0]  pnext;

  assign a_neg = acc_r[W-1];
  assign b_neg = opnd_r[W-1];
  assign diff  = a_neg ^ b_neg;
  assign ma    = a_neg ? (~acc_r + ONE) : acc_r;
  assign mb    = b_neg ? (~opnd_r + ONE) : opnd_r;
  assign sum   = acc_r + opnd_r;
  assign sub   = acc_r - opnd_r;
  assign pnext = cnt_r + ONE;

  caa_unit #(.DATA_WIDTH(W)) u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ureq),
    .x      (ux),
    .y      (uy),
    .done   (udone),
    .lo_res (ulo),
    .quot   (uq),
    .ovf    (uovf)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_OUT;
        if (kind_r inside {KIND_MUL, KIND_DIV, KIND_MOD}) begin
          if (acc_r != SIGNB && opnd_r != SIGNB &&
              (kind_r == KIND_MUL || mb != '0)) begin
            state_nxt = S_WAIT;
          end
        end else if (kind_r == KIND_POW) begin
          if (!b_neg && opnd_r != '0 && acc_r != SIGNB && ma > ONE) begin
            state_nxt = S_POWGO;
          end
        end
      end
      S_POWGO: state_nxt = S_WAIT;
      S_WAIT: begin
        if (udone) begin
          if (kind_r == KIND_POW && !uovf && pnext != opnd_r) begin
            state_nxt = S_POWGO;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and the request to the shared unit. Mul, div and mod feed the
  // two magnitudes; a power step multiplies the running power by the base
  // magnitude.
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ureq.start  = 1'b0;
    ureq.is_div = (kind_r != KIND_MUL) && (kind_r != KIND_POW);
    ux          = ma;
    uy          = mb;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_EXEC: ureq.start = (state_nxt == S_WAIT);
      S_POWGO: begin
        ureq.start = 1'b1;
        ux         = pow_r;
        uy         = ma;
      end
      S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= '0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r <= kind_t'(in_kind);
            opnd_r <= in_operand;
          end
        end
        S_EXEC: begin
          st_r <= ST_OK;
          case (kind_r)
            KIND_ADD: begin
              if (!a_neg && !b_neg && sum[W-1])      st_r <= ST_OVF;
              else if (a_neg && b_neg && !sum[W-1]) st_r <= ST_UNF;
              else                                   acc_r <= sum;
            end
            KIND_SUB: begin
              if (!a_neg && b_neg && sub[W-1])       st_r <= ST_OVF;
              else if (a_neg && !b_neg && !sub[W-1]) st_r <= ST_UNF;
              else                                   acc_r <= sub;
            end
            KIND_MUL, KIND_DIV, KIND_MOD: begin
              if (acc_r == SIGNB || opnd_r == SIGNB) st_r <= ST_OVF;
              else if (kind_r != KIND_MUL && mb == '0) st_r <= ST_DIVZ;
            end
            KIND_NEG: begin
              if (acc_r == SIGNB) st_r <= ST_OVF;
              else                acc_r <= ~acc_r + ONE;
            end
            KIND_POW: begin
              pow_r <= ONE;
              cnt_r <= '0;
              if (b_neg)                st_r <= ST_NEGEXP;
              else if (opnd_r == '0)    acc_r <= ONE;
              else if (acc_r == SIGNB)  st_r <= ST_OVF;
              else if (ma <= ONE)       acc_r <= (a_neg && opnd_r[0]) ? acc_r : ma;
            end
            default: acc_r <= '0;
          endcase
        end
        S_WAIT: begin
          if (udone) begin
            case (kind_r)
              KIND_MUL: begin
                if (uovf) st_r <= ST_OVF;
                else      acc_r <= diff ? (~ulo + ONE) : ulo;
              end
              KIND_DIV: acc_r <= diff ? (~uq + ONE) : uq;
              KIND_MOD: acc_r <= ulo;
              default: begin
                // Power: one more factor of the base magnitude per pass.
                if (uovf) begin
                  st_r <= ST_OVF;
                end else begin
                  pow_r <= ulo;
                  cnt_r <= pnext;
                  if (pnext == opnd_r) begin
                    acc_r <= (a_neg && opnd_r[0]) ? (~ulo + ONE) : ulo;
                  end
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  assign out_value  = acc_r;
  assign out_status = st_r;

endmodule

// ===== rtl/caa_unit.sv =====
module caa_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  caa_pkg::unit_req_t      req,
  input  logic [DATA_WIDTH-1:0]   x,
  input  logic [DATA_WIDTH-1:0]   y,
  output logic                    done,
  output logic [DATA_WIDTH-1:0]   lo_res,
  output logic [DATA_WIDTH-1:0]   quot,
  output logic                    ovf
);
  import caa_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);
  localparam logic [W:0] MAXMAG = {2'b00, {(W-1){1'b1}}};

  logic [W:0]    acc_r;
  logic [W-1:0]  q_r;
  logic [W-1:0]  y_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic          div_r;
  logic          ovf_r;

  logic [W:0] mul_t;
  logic [W:0] sh;
  logic [W:0] dif;
  logic       ge;

  // Multiply walks the multiplier from its top bit; once the partial product
  // passes the largest magnitude it can only grow, so the flag is sticky.
  assign mul_t = {acc_r[W-1:0], 1'b0} + (q_r[W-1] ? {1'b0, y_r} : '0);
  assign sh    = {acc_r[W-1:0], q_r[W-1]};
  assign ge    = sh >= {1'b0, y_r};
  assign dif   = sh - {1'b0, y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
        acc_r  <= '0;
        q_r    <= x;
        y_r    <= y;
        div_r  <= req.is_div;
        ovf_r  <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        if (div_r) begin
          acc_r <= ge ? dif : sh;
          q_r   <= {q_r[W-2:0], ge};
        end else begin
          q_r <= q_r << 1;
          if (!ovf_r) begin
            acc_r <= mul_t;
            if (mul_t > MAXMAG) begin
              ovf_r <= 1'b1;
            end
          end
        end
      end
    end
  end

  assign done   = done_r;
  assign lo_res = acc_r[W-1:0];
  assign quot   = q_r;
  assign ovf    = ovf_r;

endmodule

// ===== rtl/caa_checker.sv =====
module caa_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [DATA_WIDTH-1:0]  out_value,
  input logic [2:0]             out_status
);
  import caa_pkg::*;

  // A result that waits keeps its value and status.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result changed while stalled");

  // One item at a time: no new input while a result is shown.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // After an input transfer the block neither takes input nor shows a result in the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("input taken back to back");

  // The accumulator does not move between items.
  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> $stable(out_value))
    else $error("accumulator changed while idle");

endmodule

bind checked_accumulator_alu_top caa_checker #(.DATA_WIDTH(DATA_WIDTH)) u_caa_checker (.*);

// ===== sim/checked_accumulator_alu_top_tb.sv =====
`timescale 1ns / 1ps

module checked_accumulator_alu_top_tb;
  import caa_pkg::*;

  localparam int DW = 32;
  localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};
  localparam int RANDOM_ITEMS = 1460;
  localparam longint CYCLE_LIMIT = 10000000;

  // Checks results in transfer order. It keeps its own copy of the
  // accumulator and works out each result as soon as the input transfer lands.
  class acc_scoreboard;
    logic [DW-1:0] acc_model;
    logic [DW-1:0] want_value[$];
    status_t want_status[$];
    int mismatches;
    int results_seen;
    int status_hits[8];

    function new();
      acc_model = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function automatic logic [DW-1:0] magn(logic [DW-1:0] x);
      return x[DW-1] ? -x : x;
    endfunction

    // Applies one operation to the model accumulator and queues the result.
    function void note_input(kind_t kind, logic [DW-1:0] b);
      logic [DW-1:0] a;
      logic [DW-1:0] r;
      logic [DW-1:0] ma;
      logic [DW-1:0] mb;
      logic [2*DW-1:0] prod;
      logic [2*DW-1:0] pw;
      status_t st;
      bit flip;
      a = acc_model;
      r = a;
      st = ST_OK;
      flip = a[DW-1] ^ b[DW-1];
      case (kind)
        KIND_ADD: begin
          r = a + b;
          if (!a[DW-1] && !b[DW-1] && r[DW-1]) st = ST_OVF;
          else if (a[DW-1] && b[DW-1] && !r[DW-1]) st = ST_UNF;
        end
        KIND_SUB: begin
          r = a - b;
          if (!a[DW-1] && b[DW-1] && r[DW-1]) st = ST_OVF;
          else if (a[DW-1] && !b[DW-1] && !r[DW-1]) st = ST_UNF;
        end
        KIND_MUL, KIND_DIV, KIND_MOD: begin
          // Magnitude arithmetic cannot represent the most negative value.
          if (a == MOST_NEG || b == MOST_NEG) begin
            st = ST_OVF;
          end else begin
            ma = magn(a);
            mb = magn(b);
            if (kind == KIND_MUL) begin
              prod = ma * mb;
              if (prod > MOST_POS) st = ST_OVF;
              else r = flip ? -prod[DW-1:0] : prod[DW-1:0];
            end else if (mb == '0) begin
              st = ST_DIVZ;
            end else if (kind == KIND_DIV) begin
              r = flip ? -(ma / mb) : ma / mb;
            end else begin
              r = ma % mb;
            end
          end
        end
        KIND_NEG: begin
          if (a == MOST_NEG) st = ST_OVF;
          else r = -a;
        end
        KIND_POW: begin
          if (b[DW-1]) begin
            st = ST_NEGEXP;
          end else if (b == '0) begin
            r = 1;
          end else if (a == MOST_NEG) begin
            st = ST_OVF;
          end else begin
            ma = magn(a);
            if (ma <= 1) begin
              pw = ma;
            end else begin
              // A base of two or more overflows within DW steps, so the loop
              // stops early even for huge exponents.
              pw = 1;
              for (longint i = 0; i < b; i++) begin
                pw = pw * ma;
                if (pw > MOST_POS) begin
                  st = ST_OVF;
                  break;
                end
              end
            end
            if (st == ST_OK) r = (a[DW-1] && b[0]) ? -pw[DW-1:0] : pw[DW-1:0];
          end
        end
        default: r = '0;
      endcase
      if (st == ST_OK) acc_model = r;
      want_value.push_back(acc_model);
      want_status.push_back(st);
    endfunction

    function void check_result(logic [DW-1:0] value, logic [2:0] status);
      logic [DW-1:0] ev;
      status_t es;
      results_seen++;
      if (want_value.size() == 0) begin
        report_mismatch("result transfer with no expectation pending", 0, value);
        return;
      end
      ev = want_value.pop_front();
      es = want_status.pop_front();
      status_hits[es]++;
      if (value !== ev) report_mismatch("value", ev, value);
      if (status !== es) report_mismatch("status", es, status);
    endfunction

    function void report_mismatch(string what, logic [DW-1:0] want, logic [DW-1:0] got);
      mismatches++;
      $display("MISMATCH %s: expected %0h got %0h (result %0d)", what, want, got,
               results_seen);
    endfunction

    function int pending();
      return want_value.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_kind = '0;
  logic signed [DW-1:0] in_operand = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DW-1:0] out_value;
  logic [2:0] out_status;

  acc_scoreboard acc_sb = new();
  longint cycle_count = 0;
  int items_sent = 0;
  bit sender_done = 1'b0;
  // When set, both sides stop idling so the tail of the run is back to back.
  bit quiet_tail = 1'b0;
  // The sink side honors this long hold-off request once.
  bit hold_sink = 1'b0;

  always #6 clk = ~clk;

  checked_accumulator_alu_top #(.DATA_WIDTH(DW)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_operand(in_operand),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_status(out_status)
  );

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               acc_sb.pending());
      $display("checked_accumulator_alu_top verification failed");
      $finish;
    end
  end

  // Sampling is done on the rising edge, so every transfer is seen with the
  // values that the block held just before the edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) acc_sb.note_input(kind_t'(in_kind), in_operand);
    if (rst_n && out_valid && out_ready) acc_sb.check_result(out_value, out_status);
  end

  // Receiver: ready toggles in random bursts, plus one long hold-off.
  initial begin : sink
    int burst;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 15);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        burst = $urandom_range(1, 40);
        out_ready <= 1'b1;
        repeat (burst) @(posedge clk);
      end
    end
  end

  // Offers one transfer and holds it until the block takes it. A random gap
  // may come first; valid stays high between back-to-back transfers.
  task automatic send_op(kind_t kind, logic [DW-1:0] operand);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_operand <= operand;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (acc_sb.pending() != 0) @(posedge clk);
  endtask

  // Operands lean toward the edges, where the overflow checks live.
  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return $urandom_range(0, 3);
      3: return -$urandom_range(1, 3);
      4, 5: return $urandom_range(0, 200) - 100;
      6: return $urandom_range(0, 70000) - 35000;
      default: return $urandom();
    endcase
  endfunction

  // Exponents are mostly small; an occasional huge or negative one checks
  // the early stop and the negative-exponent case.
  function automatic logic [DW-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return -$urandom_range(1, 5);
      default: return $urandom_range(0, 35);
    endcase
  endfunction

  initial begin : stimulus
    kind_t k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: edges of every operation and each named special case.
    send_op(KIND_POW, 0);              // zero to the zero gives one
    send_op(KIND_DIV, 0);              // divide by zero
    send_op(KIND_MOD, 0);              // modulo by zero
    send_op(KIND_SUB, MOST_NEG);       // subtracting most negative overflows
    send_op(KIND_ADD, MOST_POS);       // 1 + max overflows
    send_op(KIND_ADD, -2);             // now -1
    send_op(KIND_ADD, MOST_NEG);       // underflow
    send_op(KIND_SUB, MOST_POS);       // -1 - max lands on most negative
    send_op(KIND_NEG, 0);              // negating most negative overflows
    send_op(KIND_MUL, 0);              // most negative side wins over zero
    send_op(KIND_POW, 0);              // exponent zero still gives one
    send_op(KIND_POW, -1);             // negative exponent
    send_op(KIND_ADD, -8);             // -7
    send_op(KIND_POW, 3);              // -343, odd power of a negative base
    send_op(KIND_MOD, -5);             // magnitude remainder, non-negative
    send_op(KIND_SUB, 10);
    send_op(KIND_DIV, -4);             // quotient truncates toward zero
    send_op(KIND_MUL, MOST_POS);       // 1 * max just fits
    send_op(KIND_POW, 32'h7fffffff);   // huge exponent, early overflow
    send_op(KIND_NEG, 0);
    send_op(KIND_CLEAR, 32'hffffffff);
    send_op(KIND_ADD, MOST_NEG);
    send_op(KIND_DIV, MOST_NEG);       // most negative operand overflows
    send_op(KIND_CLEAR, 0);

    // The sender stops until every result is in.
    drain_results();

    // Long receiver hold-off while items keep coming; with one in flight the
    // block stalls its input almost at once.
    hold_sink = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 200) quiet_tail = 1'b1;
      // Clears are kept rare so the accumulator wanders far between them.
      k = kind_t'($urandom_range(0, 6));
      if ($urandom_range(0, 40) == 0) k = KIND_CLEAR;
      // Small accumulators make multiply and power stay in range more often.
      if ($urandom_range(0, 12) == 0) begin
        send_op(KIND_CLEAR, $urandom());
        send_op(KIND_ADD, $urandom_range(0, 12) - 6);
      end
      if (k == KIND_POW) send_op(k, pick_exponent());
      else send_op(k, pick_operand());
    end

    drain_results();
    repeat (50) @(posedge clk);
    $display("sent %0d operations, checked %0d results in %0d cycles", items_sent,
             acc_sb.results_seen, cycle_count);
    $display("status mix: ok %0d, overflow %0d, underflow %0d, neg exp %0d, div0 %0d",
             acc_sb.status_hits[ST_OK], acc_sb.status_hits[ST_OVF],
             acc_sb.status_hits[ST_UNF], acc_sb.status_hits[ST_NEGEXP],
             acc_sb.status_hits[ST_DIVZ]);
    if (acc_sb.mismatches == 0 && acc_sb.pending() == 0) begin
      $display("checked_accumulator_alu_top verification clean");
    end else begin
      $display("checked_accumulator_alu_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/caa_pkg.sv
rtl/caa_unit.sv
rtl/checked_accumulator_alu_top.sv
rtl/caa_checker.sv
sim/checked_accumulator_alu_top_tb.sv
